### rtl/lsbpe_pkg.sv
// Package for the LSB payload extractor: phase encoding, result kinds, field widths.
`timescale 1ns / 1ps
package lsbpe_pkg;

    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 31;
    localparam int SKIP_W   = 10;
    localparam int CFG_IDX_W = 2;
    localparam int EXTLEN_W = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SKIP  = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_EXT_BYTE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SECRET_BYTE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MAGIC_ERR   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EXT_TOO_LONG = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EXT_SIZE    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SECRET_SIZE = 3'd5;

    localparam logic [31:0] RESET_MAGIC_WORD   = 32'd0;
    localparam logic [2:0]  RESET_MAGIC_LENGTH = 3'd2;
    localparam logic [SKIP_W-1:0] RESET_HEADER_SKIP = 10'd54;

    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_SKIP    = 8'b0000_0010,
        PH_MAGIC   = 8'b0000_0100,
        PH_EXTLEN  = 8'b0000_1000,
        PH_EXTBYTE = 8'b0001_0000,
        PH_SECLEN  = 8'b0010_0000,
        PH_SECRET  = 8'b0100_0000,
        PH_DONE    = 8'b1000_0000
    } phase_t;

endpackage

### rtl/lsb_stego_payload_extractor.sv
// Top level of the LSB steganography payload extractor.
//
//  channel   direction  handshake              payload
//  carrier   in         carrier_valid / stall  carrier_byte, start_of_file
//  result    out        result_valid / stall   result_kind, result_value, last_of_file
//  cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each carrier word passes through the input register and the combinational decode step,
// which writes the result register; one word per cycle while the result is not stalled.
// The decode step is a single shift, counter update and compare per word.
// Reset leaves the decoder idle until a word with start_of_file set arrives.
// A stalled result holds the result register; the input register then holds, and
// carrier_stall rises only while that input register is full and cannot advance.
`timescale 1ns / 1ps
module lsb_stego_payload_extractor #(
    parameter int MAX_EXTENSION = 9
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           carrier_valid,
    output logic                           carrier_stall,
    input  logic [7:0]                     carrier_byte,
    input  logic                           start_of_file,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [lsbpe_pkg::KIND_W-1:0]   result_kind,
    output logic [lsbpe_pkg::VALUE_W-1:0]  result_value,
    output logic                           last_of_file,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lsbpe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);
    import lsbpe_pkg::*;

    localparam logic [VALUE_W-1:0] MAX_EXT_VAL = VALUE_W'(MAX_EXTENSION);

    // configuration
    logic [31:0]       magic_word_reg;
    logic [2:0]        magic_length_reg;
    logic [SKIP_W-1:0] header_skip_reg;

    // input register
    logic s1_valid_reg;
    logic s1_bit_reg;
    logic s1_sof_reg;

    // decoder state
    phase_t              phase_reg, phase_next;
    logic [SKIP_W-1:0]   skip_count_reg, skip_count_next;
    logic [4:0]          bit_count_reg, bit_count_next;
    logic [31:0]         bit_shift_reg, bit_shift_next;
    logic [VALUE_W-1:0]  items_done_reg, items_done_next;
    logic [EXTLEN_W-1:0] ext_length_reg, ext_length_next;
    logic [VALUE_W-1:0]  secret_length_reg, secret_length_next;
    logic [31:0]         magic_gathered_reg, magic_gathered_next;

    // result register
    logic               out_valid_reg;
    logic [KIND_W-1:0]  out_kind_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_last_reg;

    logic               emit;
    logic [KIND_W-1:0]  emit_kind;
    logic [VALUE_W-1:0] emit_value;
    logic               emit_last;

    logic advance;
    logic accept;

    assign advance       = !out_valid_reg || !result_stall;
    assign carrier_stall = s1_valid_reg && !advance;
    assign accept        = carrier_valid && !carrier_stall;
    assign cfg_ready     = 1'b1;

    assign result_valid = out_valid_reg;
    assign result_kind  = out_kind_reg;
    assign result_value = out_value_reg;
    assign last_of_file = out_last_reg;

    always_comb
    begin
        phase_t             ph;
        logic [SKIP_W-1:0]  skc;
        logic [4:0]         bc;
        logic [31:0]        bs;
        logic [VALUE_W-1:0] itd;
        logic [VALUE_W-1:0] itd_inc;
        logic [EXTLEN_W-1:0] exl;
        logic [VALUE_W-1:0] scl;
        logic [31:0]        mg;
        logic [31:0]        w;
        logic [VALUE_W-1:0] sz;
        logic [2:0]         len;
        logic [31:0]        mask;
        logic               done;
        logic               go;

        ph  = phase_reg;
        skc = skip_count_reg;
        bc  = bit_count_reg;
        bs  = bit_shift_reg;
        itd = items_done_reg;
        exl = ext_length_reg;
        scl = secret_length_reg;
        mg  = magic_gathered_reg;
        emit       = 1'b0;
        emit_kind  = KIND_EXT_BYTE;
        emit_value = '0;
        emit_last  = 1'b0;
        w    = '0;
        sz   = '0;
        len  = 3'd1;
        mask = '0;
        done = 1'b0;
        go   = 1'b0;
        itd_inc = '0;

        if (s1_sof_reg)
        begin
            ph  = PH_SKIP;
            skc = '0;
            bc  = '0;
            bs  = '0;
            itd = '0;
            exl = '0;
            scl = '0;
            mg  = '0;
        end

        go = (ph != PH_IDLE) && (ph != PH_DONE);

        if (go && ph == PH_SKIP)
        begin
            if (skc < header_skip_reg)
            begin
                skc = skc + SKIP_W'(1);
                go  = 1'b0;
            end
            else
            begin
                ph = PH_MAGIC;
            end
        end

        if (go)
        begin
            bs   = {bs[30:0], s1_bit_reg};
            done = (ph == PH_EXTLEN || ph == PH_SECLEN) ? (bc == 5'd31) : (bc == 5'd7);
            bc   = bc + 5'd1;
            if (done)
            begin
                w  = bs;
                bc = '0;
                bs = '0;
                sz = w[31] ? '0 : w[VALUE_W-1:0];
                itd_inc = itd + VALUE_W'(1);
                case (ph)
                    PH_MAGIC:
                    begin
                        case (magic_length_reg) inside
                            3'd0, 3'd1: len = 3'd1;
                            3'd2:       len = 3'd2;
                            3'd3:       len = 3'd3;
                            default:    len = 3'd4;
                        endcase
                        mask = {{8{len == 3'd4}}, {8{len >= 3'd3}}, {8{len >= 3'd2}}, 8'hFF};
                        mg   = {mg[23:0], w[7:0]};
                        itd  = itd_inc;
                        if (itd_inc >= VALUE_W'(len))
                        begin
                            itd = '0;
                            if ((mg & mask) != (magic_word_reg & mask))
                            begin
                                ph        = PH_DONE;
                                emit      = 1'b1;
                                emit_kind = KIND_MAGIC_ERR;
                                emit_last = 1'b1;
                            end
                            else
                            begin
                                ph = PH_EXTLEN;
                            end
                        end
                    end
                    PH_EXTLEN:
                    begin
                        emit = 1'b1;
                        if (sz > MAX_EXT_VAL)
                        begin
                            ph        = PH_DONE;
                            emit_kind = KIND_EXT_TOO_LONG;
                            emit_last = 1'b1;
                        end
                        else
                        begin
                            exl        = sz[EXTLEN_W-1:0];
                            itd        = '0;
                            ph         = (sz == '0) ? PH_SECLEN : PH_EXTBYTE;
                            emit_kind  = KIND_EXT_SIZE;
                            emit_value = sz;
                        end
                    end
                    PH_EXTBYTE:
                    begin
                        itd = itd_inc;
                        if (itd_inc >= VALUE_W'(exl))
                        begin
                            itd = '0;
                            ph  = PH_SECLEN;
                        end
                        emit       = 1'b1;
                        emit_kind  = KIND_EXT_BYTE;
                        emit_value = VALUE_W'(w[7:0]);
                    end
                    PH_SECLEN:
                    begin
                        scl        = sz;
                        itd        = '0;
                        emit       = 1'b1;
                        emit_kind  = KIND_SECRET_SIZE;
                        emit_value = sz;
                        if (sz == '0)
                        begin
                            ph        = PH_DONE;
                            emit_last = 1'b1;
                        end
                        else
                        begin
                            ph = PH_SECRET;
                        end
                    end
                    PH_SECRET:
                    begin
                        itd        = itd_inc;
                        emit       = 1'b1;
                        emit_kind  = KIND_SECRET_BYTE;
                        emit_value = VALUE_W'(w[7:0]);
                        if (itd_inc >= scl)
                        begin
                            ph        = PH_DONE;
                            emit_last = 1'b1;
                        end
                    end
                    default:
                    begin
                        ph = PH_DONE;
                    end
                endcase
            end
        end

        phase_next          = ph;
        skip_count_next     = skc;
        bit_count_next      = bc;
        bit_shift_next      = bs;
        items_done_next     = itd;
        ext_length_next     = exl;
        secret_length_next  = scl;
        magic_gathered_next = mg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg   <= RESET_MAGIC_WORD;
            magic_length_reg <= RESET_MAGIC_LENGTH;
            header_skip_reg  <= RESET_HEADER_SKIP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAGIC_WORD:   magic_word_reg   <= cfg_data;
                CFG_MAGIC_LENGTH: magic_length_reg <= cfg_data[2:0];
                CFG_HEADER_SKIP:  header_skip_reg  <= cfg_data[SKIP_W-1:0];
                default:          ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_bit_reg <= carrier_byte[0];
            s1_sof_reg <= start_of_file;
        end
    end

    // decoder state, stepped once per word leaving the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            skip_count_reg     <= '0;
            bit_count_reg      <= '0;
            bit_shift_reg      <= '0;
            items_done_reg     <= '0;
            ext_length_reg     <= '0;
            secret_length_reg  <= '0;
            magic_gathered_reg <= '0;
        end
        else if (s1_valid_reg && advance)
        begin
            phase_reg          <= phase_next;
            skip_count_reg     <= skip_count_next;
            bit_count_reg      <= bit_count_next;
            bit_shift_reg      <= bit_shift_next;
            items_done_reg     <= items_done_next;
            ext_length_reg     <= ext_length_next;
            secret_length_reg  <= secret_length_next;
            magic_gathered_reg <= magic_gathered_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg && emit)
        begin
            out_kind_reg  <= emit_kind;
            out_value_reg <= emit_value;
            out_last_reg  <= emit_last;
        end
    end

endmodule

### bench/lsb_stego_payload_extractor_test.sv
// Self-checking bench for the LSB payload extractor: directed script, random files, predictor.
`timescale 1ns / 1ps
module lsb_stego_payload_extractor_test;
    import lsbpe_pkg::*;

    localparam int EXT_LIMIT = 9;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } result_t;

    typedef enum bit {ROW_BITS, ROW_CFG} row_op_t;

    typedef struct packed {
        row_op_t     op;
        bit          sof;
        int          nbits;
        logic [31:0] data;
        logic [6:0]  fill;
        bit          typed;
        result_t     want;
        logic [31:0] cfg_word;
        logic [2:0]  cfg_len;
        logic [9:0]  cfg_skip;
    } script_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 carrier_valid;
    logic                 carrier_stall;
    logic [7:0]           carrier_byte;
    logic                 start_of_file;
    logic                 result_valid;
    logic                 result_stall;
    logic [KIND_W-1:0]    result_kind;
    logic [VALUE_W-1:0]   result_value;
    logic                 last_of_file;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    // predictor copy of the registers
    logic [31:0] cfg_magic_word  = RESET_MAGIC_WORD;
    logic [2:0]  cfg_magic_len   = RESET_MAGIC_LENGTH;
    logic [9:0]  cfg_header_skip = RESET_HEADER_SKIP;

    // predictor copy of the decoder state
    phase_t      ph        = PH_IDLE;
    logic [9:0]  skip_cnt  = '0;
    logic [4:0]  bit_cnt   = '0;
    logic [31:0] shift_reg = '0;
    logic [30:0] done_cnt  = '0;
    logic [3:0]  ext_len   = '0;
    logic [30:0] sec_len   = '0;
    logic [31:0] magic_acc = '0;

    result_t     awaited_results[$];
    script_row_t script[$];
    int          mismatch_count = 0;
    int          send_idle_pct  = 18;
    int          recv_idle_pct  = 64;

    lsb_stego_payload_extractor #(.MAX_EXTENSION(EXT_LIMIT)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .carrier_valid (carrier_valid),
        .carrier_stall (carrier_stall),
        .carrier_byte  (carrier_byte),
        .start_of_file (start_of_file),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_kind   (result_kind),
        .result_value  (result_value),
        .last_of_file  (last_of_file),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic result_t result_word(input logic [KIND_W-1:0] kind,
                                            input logic [VALUE_W-1:0] value,
                                            input logic last);
        result_t r;
        r.kind  = kind;
        r.value = value;
        r.last  = last;
        return r;
    endfunction

    // One carrier byte through the decoder; returns 1 when it yields a result word.
    function automatic bit decode_carrier(input logic [7:0] b, input logic sof,
                                          output result_t r);
        logic [31:0] w;
        logic [31:0] sz;
        logic [31:0] mask;
        int unsigned mlen;
        bit          word_done;
        r = '0;
        if (sof)
        begin
            ph        = PH_SKIP;
            skip_cnt  = '0;
            bit_cnt   = '0;
            shift_reg = '0;
            done_cnt  = '0;
            ext_len   = '0;
            sec_len   = '0;
            magic_acc = '0;
        end
        if (ph == PH_IDLE || ph == PH_DONE)
            return 0;
        if (ph == PH_SKIP)
        begin
            if (skip_cnt < cfg_header_skip)
            begin
                skip_cnt = skip_cnt + 1'b1;
                return 0;
            end
            ph = PH_MAGIC;
        end
        shift_reg = {shift_reg[30:0], b[0]};
        word_done = (ph == PH_EXTLEN || ph == PH_SECLEN) ? (bit_cnt == 5'd31)
                                                         : (bit_cnt == 5'd7);
        bit_cnt = bit_cnt + 1'b1;
        if (!word_done)
            return 0;
        w         = shift_reg;
        bit_cnt   = '0;
        shift_reg = '0;
        sz        = w[31] ? 32'd0 : w;   // negative sizes read as zero
        case (ph)
            PH_MAGIC:
            begin
                mlen = (cfg_magic_len == 0) ? 1 : (cfg_magic_len > 4) ? 4 : cfg_magic_len;
                magic_acc = {magic_acc[23:0], w[7:0]};
                done_cnt  = done_cnt + 1'b1;
                if (done_cnt < mlen)
                    return 0;
                mask     = (mlen == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * mlen)) - 1);
                done_cnt = '0;
                if ((magic_acc & mask) != (cfg_magic_word & mask))
                begin
                    ph = PH_DONE;
                    r  = result_word(KIND_MAGIC_ERR, '0, 1'b1);
                    return 1;
                end
                ph = PH_EXTLEN;
                return 0;
            end
            PH_EXTLEN:
            begin
                if (sz > EXT_LIMIT)
                begin
                    ph = PH_DONE;
                    r  = result_word(KIND_EXT_TOO_LONG, '0, 1'b1);
                    return 1;
                end
                ext_len  = sz[3:0];
                done_cnt = '0;
                ph       = (sz == 0) ? PH_SECLEN : PH_EXTBYTE;
                r        = result_word(KIND_EXT_SIZE, sz[30:0], 1'b0);
                return 1;
            end
            PH_EXTBYTE:
            begin
                done_cnt = done_cnt + 1'b1;
                if (done_cnt >= ext_len)
                begin
                    done_cnt = '0;
                    ph       = PH_SECLEN;
                end
                r = result_word(KIND_EXT_BYTE, {23'd0, w[7:0]}, 1'b0);
                return 1;
            end
            PH_SECLEN:
            begin
                sec_len  = sz[30:0];
                done_cnt = '0;
                if (sz == 0)
                begin
                    ph = PH_DONE;
                    r  = result_word(KIND_SECRET_SIZE, '0, 1'b1);
                    return 1;
                end
                ph = PH_SECRET;
                r  = result_word(KIND_SECRET_SIZE, sz[30:0], 1'b0);
                return 1;
            end
            PH_SECRET:
            begin
                done_cnt = done_cnt + 1'b1;
                if (done_cnt >= sec_len)
                begin
                    ph = PH_DONE;
                    r  = result_word(KIND_SECRET_BYTE, {23'd0, w[7:0]}, 1'b1);
                    return 1;
                end
                r = result_word(KIND_SECRET_BYTE, {23'd0, w[7:0]}, 1'b0);
                return 1;
            end
            default:
            begin
                ph = PH_DONE;
                return 0;
            end
        endcase
    endfunction

    function automatic void flag_mismatch(input string what, input result_t want,
                                          input result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%s): exp kind=%0d value=%h last=%b, got kind=%0d value=%h last=%b",
                     what, want.kind, want.value, want.last, got.kind, got.value, got.last);
    endfunction

    function automatic void add_bits(input bit sof, input int nbits, input logic [31:0] data,
                                     input logic [6:0] fill);
        script_row_t row;
        row       = '0;
        row.op    = ROW_BITS;
        row.sof   = sof;
        row.nbits = nbits;
        row.data  = data;
        row.fill  = fill;
        script.push_back(row);
    endfunction

    // Last byte of the row must give exactly this word.
    function automatic void add_checked(input bit sof, input int nbits, input logic [31:0] data,
                                        input logic [6:0] fill, input logic [KIND_W-1:0] kind,
                                        input logic [VALUE_W-1:0] value, input logic last);
        script_row_t row;
        row       = '0;
        row.op    = ROW_BITS;
        row.sof   = sof;
        row.nbits = nbits;
        row.data  = data;
        row.fill  = fill;
        row.typed = 1'b1;
        row.want  = result_word(kind, value, last);
        script.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [31:0] word, input logic [2:0] len,
                                    input logic [9:0] skip);
        script_row_t row;
        row          = '0;
        row.op       = ROW_CFG;
        row.cfg_word = word;
        row.cfg_len  = len;
        row.cfg_skip = skip;
        script.push_back(row);
    endfunction

    // Called at a falling edge; returns at a falling edge.
    task automatic feed(input logic [7:0] b, input logic sof, input bit typed,
                        input result_t want);
        result_t got;
        bit      has;
        while ($urandom_range(99) < send_idle_pct)
        begin
            carrier_valid <= 1'b0;
            @(negedge clk);
        end
        carrier_valid <= 1'b1;
        carrier_byte  <= b;
        start_of_file <= sof;
        do @(posedge clk); while (carrier_stall);
        @(negedge clk);
        has = decode_carrier(b, sof, got);
        if (typed)
        begin
            awaited_results.push_back(want);
        end
        else if (has)
        begin
            awaited_results.push_back(got);
        end
    endtask

    task automatic settle();
        carrier_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic write_config(input logic [31:0] word, input logic [2:0] len,
                                input logic [9:0] skip);
        put_reg(CFG_MAGIC_WORD, word);
        put_reg(CFG_MAGIC_LENGTH, {29'd0, len});
        put_reg(CFG_HEADER_SKIP, {22'd0, skip});
        cfg_valid       <= 1'b0;
        cfg_magic_word  = word;
        cfg_magic_len   = len;
        cfg_header_skip = skip;
    endtask

    task automatic push_field(ref bit q[$], input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            q.push_back(v[i]);
    endtask

    // One carrier file: mostly well formed, some noise, some cut short.
    task automatic random_file(output int used);
        bit          stream[$];
        int          mlen;
        int          n;
        int          r;
        int          flip;
        logic [31:0] v;
        logic [31:0] ext_sz;
        logic [31:0] sec_sz;
        logic        first;
        first = 1'b1;
        if ($urandom_range(99) < 10)
        begin
            n = $urandom_range(8, 60);
            repeat (n) stream.push_back(1'($urandom));
        end
        else
        begin
            mlen = (cfg_magic_len == 0) ? 1 : (cfg_magic_len > 4) ? 4 : cfg_magic_len;
            v = cfg_magic_word;
            if ($urandom_range(99) < 10)
            begin
                flip    = $urandom_range(0, 8 * mlen - 1);
                v[flip] = ~v[flip];
            end
            push_field(stream, v, 8 * mlen);

            r = $urandom_range(99);
            if (r < 75)
                ext_sz = $urandom_range(0, EXT_LIMIT);
            else if (r < 85)
                ext_sz = $urandom_range(EXT_LIMIT + 1, 15);
            else if (r < 93)
                ext_sz = {1'b1, 31'($urandom)};
            else
                ext_sz = $urandom;
            push_field(stream, ext_sz, 32);
            if (!ext_sz[31] && ext_sz <= EXT_LIMIT)
                repeat (ext_sz) push_field(stream, $urandom, 8);

            r = $urandom_range(99);
            if (r < 80)
                sec_sz = $urandom_range(0, 6);
            else if (r < 90)
                sec_sz = {1'b1, 31'($urandom)};
            else
                sec_sz = {1'b0, 31'($urandom)};
            push_field(stream, sec_sz, 32);
            // huge secrets are abandoned by the next start of file
            n = (sec_sz <= 6) ? sec_sz : $urandom_range(0, 6);
            repeat (n) push_field(stream, $urandom, 8);

            if ($urandom_range(99) < 12)
            begin
                n = $urandom_range(1, stream.size());
                while (stream.size() > n)
                    void'(stream.pop_back());
            end
        end

        repeat (cfg_header_skip)
        begin
            feed(8'($urandom), first, 1'b0, '0);
            first = 1'b0;
        end
        foreach (stream[i])
        begin
            feed({7'($urandom), stream[i]}, first, 1'b0, '0);
            first = 1'b0;
        end
        if ($urandom_range(99) < 20)
            repeat ($urandom_range(1, 6)) feed(8'($urandom), 1'b0, 1'b0, '0);
        used = stream.size();
    endtask

    always @(negedge clk)
        result_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            got = {result_kind, result_value, last_of_file};
            if (awaited_results.size() == 0)
                flag_mismatch("unexpected word", '0, got);
            else
            begin
                want = awaited_results.pop_front();
                if (got.kind !== want.kind || got.value !== want.value
                    || got.last !== want.last)
                    flag_mismatch("wrong field", want, got);
            end
        end
    end

    initial
    begin
        int          bitpos;
        logic        lsb;
        int          used;
        int          phase_items;
        script_row_t row;

        rst_n         = 1'b0;
        carrier_valid = 1'b0;
        carrier_byte  = '0;
        start_of_file = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_MAGIC_WORD;
        cfg_data      = '0;

        // reset settings: magic 0 over two chars, 54 header bytes
        add_bits(1'b0, 8, 32'hFF, 7'h7F);                 // before any start: ignored
        add_bits(1'b1, 54, 32'h0, 7'h7F);
        add_bits(1'b0, 16, 32'h0, 7'h00);
        add_checked(1'b0, 32, 32'h8000_0000, 7'h55, KIND_EXT_SIZE, '0, 1'b0);
        add_checked(1'b0, 32, 32'h3, 7'h2A, KIND_SECRET_SIZE, 31'd3, 1'b0);
        add_bits(1'b0, 8, 32'hFF, 7'h00);
        add_bits(1'b0, 8, 32'h00, 7'h7F);
        add_checked(1'b0, 8, 32'hA5, 7'h55, KIND_SECRET_BYTE, 31'hA5, 1'b1);
        add_bits(1'b0, 8, 32'hFF, 7'h7F);                 // after the last word: ignored
        // length 0 counts as 1, only low byte compared, no header
        add_cfg(32'hFFFF_FF5A, 3'd0, 10'd0);
        add_bits(1'b1, 8, 32'h5A, 7'h00);
        add_checked(1'b0, 32, EXT_LIMIT, 7'h7F, KIND_EXT_SIZE, 31'(EXT_LIMIT), 1'b0);
        add_bits(1'b0, 16, 32'h00FF, 7'h2A);
        add_bits(1'b1, 8, 32'h5A, 7'h55);                 // restart mid-extension
        add_checked(1'b0, 32, EXT_LIMIT + 1, 7'h00, KIND_EXT_TOO_LONG, '0, 1'b1);
        add_checked(1'b1, 8, 32'h5B, 7'h7F, KIND_MAGIC_ERR, '0, 1'b1);
        add_bits(1'b1, 8, 32'h5A, 7'h2A);
        add_checked(1'b0, 32, 32'h2, 7'h55, KIND_EXT_SIZE, 31'd2, 1'b0);
        add_bits(1'b0, 16, 32'h00FF, 7'h00);
        add_checked(1'b0, 32, 32'h0, 7'h7F, KIND_SECRET_SIZE, '0, 1'b1);
        // length 7 counts as 4, all four bytes compared
        add_cfg(32'hDEAD_BEEF, 3'd7, 10'd0);
        add_bits(1'b1, 32, 32'hDEAD_BEEF, 7'h00);
        add_checked(1'b0, 32, 32'hFFFF_FFFF, 7'h7F, KIND_EXT_SIZE, '0, 1'b0);
        add_checked(1'b0, 32, 32'h1, 7'h2A, KIND_SECRET_SIZE, 31'd1, 1'b0);
        add_checked(1'b0, 8, 32'h81, 7'h55, KIND_SECRET_BYTE, 31'h81, 1'b1);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            row = script[i];
            if (row.op == ROW_CFG)
            begin
                settle();
                write_config(row.cfg_word, row.cfg_len, row.cfg_skip);
            end
            else
                for (int k = 0; k < row.nbits; k++)
                begin
                    bitpos = row.nbits - 1 - k;
                    lsb    = (bitpos < 32) ? row.data[bitpos] : 1'b0;
                    feed({row.fill, lsb}, row.sof && k == 0,
                         row.typed && k == row.nbits - 1, row.want);
                end
        end

        for (int p = 0; p < 3; p++)
        begin
            settle();
            case (p)
                0:       begin send_idle_pct = 18; recv_idle_pct = 64; end
                1:       begin send_idle_pct = 64; recv_idle_pct = 18; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            write_config($urandom, 3'($urandom_range(0, 7)), 10'($urandom_range(0, 12)));
            phase_items = 0;
            while (phase_items < 60)
            begin
                random_file(used);
                phase_items += used;
            end
        end

        settle();
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
